[sv/fbcpe_pkg.sv]
// Shared types, codes and defaults for the framebuffer change pixel expander.
package fbcpe_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 1120;
   localparam int SCREEN_HEIGHT_DEFAULT = 832;

   localparam int ROW_WIDTH    = 10;
   localparam int COLUMN_WIDTH = 11;
   localparam int DATA_WIDTH   = 32;
   localparam int RGB_WIDTH    = 24;
   localparam int SHADOW_WIDTH = RGB_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [1:0] MODE_MONO   = 2'd0;
   localparam logic [1:0] MODE_COLOR  = 2'd1;
   localparam logic [1:0] MODE_TRUE   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_MODE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_ZERO  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_ONE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_TWO   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PALETTE_THREE = 3'd4;

   localparam logic [RGB_WIDTH-1:0] PALETTE_ZERO_RESET  = 24'hFFFFFF;
   localparam logic [RGB_WIDTH-1:0] PALETTE_ONE_RESET   = 24'hAAAAAA;
   localparam logic [RGB_WIDTH-1:0] PALETTE_TWO_RESET   = 24'h555555;
   localparam logic [RGB_WIDTH-1:0] PALETTE_THREE_RESET = 24'h000000;

   typedef logic [RGB_WIDTH-1:0] rgb_type;
   typedef rgb_type [3:0] palette_type;

   typedef struct packed {
      logic [COLUMN_WIDTH-1:0] column;
      logic [ROW_WIDTH-1:0]    row;
      logic [RGB_WIDTH-1:0]    word;
      logic [1:0]              mode;
   } item_type;

endpackage

[sv/fbcpe_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module fbcpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/fbcpe_front.sv]
// Front end: accepts words, computes the shadow address, compares and updates the shadow.
module fbcpe_front #(
   parameter int SCREEN_WIDTH  = fbcpe_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = fbcpe_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fbcpe_pkg::ROW_WIDTH-1:0]      req_row,
   input  logic [fbcpe_pkg::COLUMN_WIDTH-1:0]   req_word_column,
   input  logic [fbcpe_pkg::DATA_WIDTH-1:0]     req_word_data,
   input  logic                                 req_force_req,
   input  logic [1:0]                           pixel_mode,
   input  logic                                 queue_ready,
   output logic                                 queue_push,
   output fbcpe_pkg::item_type                  queue_item
);
   import fbcpe_pkg::*;

   localparam int Depth     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AddrWidth = $clog2(Depth);
   localparam int MonoLimit = SCREEN_WIDTH / 4;

   logic                    clear_ff, clear_in;
   logic [AddrWidth-1:0]    clear_addr_ff, clear_addr_in;

   logic                    s1_valid_ff, s1_keep_ff, s1_force_ff;
   logic [ROW_WIDTH-1:0]    s1_row_ff;
   logic [COLUMN_WIDTH-1:0] s1_col_ff;
   logic [RGB_WIDTH-1:0]    s1_word_ff;
   logic [1:0]              s1_mode_ff;

   logic                    s2_valid_ff, s2_keep_ff, s2_force_ff;
   logic [AddrWidth-1:0]    s2_idx_ff, s2_idx_in;
   logic [ROW_WIDTH-1:0]    s2_row_ff;
   logic [COLUMN_WIDTH-1:0] s2_col_ff;
   logic [RGB_WIDTH-1:0]    s2_word_ff;
   logic [1:0]              s2_mode_ff;

   logic                    s3_valid_ff, s3_keep_ff, s3_force_ff;
   logic [AddrWidth-1:0]    s3_idx_ff;
   logic [ROW_WIDTH-1:0]    s3_row_ff;
   logic [COLUMN_WIDTH-1:0] s3_col_ff;
   logic [RGB_WIDTH-1:0]    s3_word_ff;
   logic [1:0]              s3_mode_ff;

   logic                    bypass_ff, bypass_in;
   logic [RGB_WIDTH-1:0]    bypass_word_ff;

   logic                    advance, accept, keep_in, s3_emit;
   logic [31:0]             col_limit;
   logic [RGB_WIDTH-1:0]    word_in;
   logic                    shadow_hit_valid;
   logic [RGB_WIDTH-1:0]    shadow_hit_word;
   logic                    ram_we;
   logic [AddrWidth-1:0]    ram_waddr;
   logic [SHADOW_WIDTH-1:0] ram_wdata, ram_rdata;

   // Input classification.
   always_comb begin
      col_limit = (pixel_mode == MODE_MONO) ? 32'(MonoLimit) : 32'(SCREEN_WIDTH);
      keep_in = (pixel_mode != MODE_UNUSED)
                && ({22'd0, req_row} < 32'(SCREEN_HEIGHT))
                && ({21'd0, req_word_column} < col_limit);
      unique case (pixel_mode)
         MODE_MONO:  word_in = {16'd0, req_word_data[7:0]};
         MODE_COLOR: word_in = {8'd0, req_word_data[15:0]};
         default:    word_in = req_word_data[31:8];
      endcase
   end

   assign s2_idx_in = AddrWidth'(s1_row_ff) * AddrWidth'(SCREEN_WIDTH)
                      + AddrWidth'(s1_col_ff);

   // The word one stage ahead is written in the same cycle as this word is read.
   assign shadow_hit_valid = bypass_ff ? 1'b1 : ram_rdata[RGB_WIDTH];
   assign shadow_hit_word  = bypass_ff ? bypass_word_ff : ram_rdata[RGB_WIDTH-1:0];
   assign s3_emit = s3_keep_ff
                    && (!shadow_hit_valid || shadow_hit_word != s3_word_ff || s3_force_ff);

   assign advance    = !(s3_valid_ff && s3_emit && !queue_ready);
   assign req_ready  = advance && !clear_ff;
   assign accept     = req_valid && req_ready;
   assign queue_push = s3_valid_ff && s3_emit && queue_ready;
   assign bypass_in  = queue_push && (s2_idx_ff == s3_idx_ff);

   assign queue_item.column = s3_col_ff;
   assign queue_item.row    = s3_row_ff;
   assign queue_item.word   = s3_word_ff;
   assign queue_item.mode   = s3_mode_ff;

   // Clearing pass over the shadow after reset.
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == AddrWidth'(Depth - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   assign ram_we    = clear_ff || queue_push;
   assign ram_waddr = clear_ff ? clear_addr_ff : s3_idx_ff;
   assign ram_wdata = clear_ff ? '0 : {1'b1, s3_word_ff};

   fbcpe_ram #(
      .WIDTH (SHADOW_WIDTH),
      .DEPTH (Depth)
   ) u_shadow (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (advance),
      .raddr (s2_idx_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         bypass_ff     <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            bypass_ff   <= bypass_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_keep_ff     <= keep_in;
         s1_force_ff    <= req_force_req;
         s1_row_ff      <= req_row;
         s1_col_ff      <= req_word_column;
         s1_word_ff     <= word_in;
         s1_mode_ff     <= pixel_mode;
         s2_keep_ff     <= s1_keep_ff;
         s2_force_ff    <= s1_force_ff;
         s2_idx_ff      <= s2_idx_in;
         s2_row_ff      <= s1_row_ff;
         s2_col_ff      <= s1_col_ff;
         s2_word_ff     <= s1_word_ff;
         s2_mode_ff     <= s1_mode_ff;
         s3_keep_ff     <= s2_keep_ff;
         s3_force_ff    <= s2_force_ff;
         s3_idx_ff      <= s2_idx_ff;
         s3_row_ff      <= s2_row_ff;
         s3_col_ff      <= s2_col_ff;
         s3_word_ff     <= s2_word_ff;
         s3_mode_ff     <= s2_mode_ff;
         bypass_word_ff <= s3_word_ff;
      end
   end

   a_no_push_while_clearing: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !clear_ff)
      else $error("Shadow update during clearing pass.");

   a_stall_holds_compare: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !advance) |=> (s3_valid_ff && $stable(s3_idx_ff) && $stable(s3_word_ff)))
      else $error("Compare stage changed while stalled.");

endmodule

[sv/fbcpe_queue.sv]
// Short first-word-fall-through queue of changed words between front and back end.
module fbcpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fbcpe_pkg::item_type push_item,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output fbcpe_pkg::item_type head_item
);
   import fbcpe_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);

   item_type              entries_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wptr_ff, rptr_ff;
   logic [PtrWidth:0]     count_ff, count_in;

   assign push_ready = count_ff != (PtrWidth + 1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = entries_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_ready || pop))
      else $error("Queue written while full.");

endmodule

[sv/fbcpe_back.sv]
// Back end: expands queued words into pixels and holds the result word.
module fbcpe_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  fbcpe_pkg::item_type                 head_item,
   output logic                                pop,
   input  fbcpe_pkg::palette_type              palette,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fbcpe_pkg::COLUMN_WIDTH-1:0]  rsp_pixel_x,
   output logic [fbcpe_pkg::ROW_WIDTH-1:0]     rsp_pixel_y,
   output logic [fbcpe_pkg::RGB_WIDTH-1:0]     rsp_pixel_rgb,
   output logic                                rsp_last
);
   import fbcpe_pkg::*;

   logic [1:0]              sub_ff, sub_in;
   logic                    rsp_valid_ff;
   logic [COLUMN_WIDTH-1:0] x_ff, x_in;
   logic [ROW_WIDTH-1:0]    y_ff;
   logic [RGB_WIDTH-1:0]    rgb_ff, rgb_in;
   logic                    last_ff, last_in;
   logic                    out_free, emit;
   logic [1:0]              code;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = head_valid && out_free;

   always_comb begin
      case (sub_ff)
         2'd0:    code = head_item.word[7:6];
         2'd1:    code = head_item.word[5:4];
         2'd2:    code = head_item.word[3:2];
         default: code = head_item.word[1:0];
      endcase
      unique case (head_item.mode)
         MODE_MONO: begin
            rgb_in  = palette[code];
            x_in    = COLUMN_WIDTH'({head_item.column, sub_ff});
            last_in = (sub_ff == 2'd3);
         end
         MODE_COLOR: begin
            rgb_in  = {head_item.word[15:12], head_item.word[15:12],
                       head_item.word[11:8], head_item.word[11:8],
                       head_item.word[7:4], head_item.word[7:4]};
            x_in    = head_item.column;
            last_in = 1'b1;
         end
         default: begin
            rgb_in  = head_item.word;
            x_in    = head_item.column;
            last_in = 1'b1;
         end
      endcase
      sub_in = sub_ff;
      if (emit) begin
         sub_in = last_in ? 2'd0 : sub_ff + 2'd1;
      end
   end

   assign pop = emit && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         x_ff    <= x_in;
         y_ff    <= head_item.row;
         rgb_ff  <= rgb_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_x   = x_ff;
   assign rsp_pixel_y   = y_ff;
   assign rsp_pixel_rgb = rgb_ff;
   assign rsp_last      = last_ff;

   a_single_pixel_modes_pop: assert property (@(posedge clock) disable iff (reset)
      (emit && head_item.mode != MODE_MONO) |-> pop)
      else $error("Single pixel word not retired after one pixel.");

   a_sub_reset_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (sub_ff == 2'd0))
      else $error("Pixel counter not cleared after the last pixel.");

endmodule

[sv/framebuffer_change_pixel_expander.sv]
// Framebuffer change pixel expander top level with configuration registers.
// Takes one framebuffer word per cycle on req_ while req_ready is high, and emits
// RGB888 pixels on rsp_ only for words that differ from the shadow copy at their
// position, or that carry the force flag. A changed mono word gives four pixels;
// a changed color or true color word gives one pixel; unchanged or out of range
// words give nothing at the output. Words pass the compare pipeline s1, s2, s3
// around the shadow RAM, which has one write and one read port, and then a four
// word queue before the expander. After reset the shadow RAM is cleared one
// entry a cycle, over all SCREEN_WIDTH * SCREEN_HEIGHT entries (931840 at the
// default size); req_ready stays low during that pass, while csr_ writes are
// taken at any time.
module framebuffer_change_pixel_expander #(
   parameter int SCREEN_WIDTH  = fbcpe_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = fbcpe_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [fbcpe_pkg::ROW_WIDTH-1:0]        req_row,
   input  logic [fbcpe_pkg::COLUMN_WIDTH-1:0]     req_word_column,
   input  logic [fbcpe_pkg::DATA_WIDTH-1:0]       req_word_data,
   input  logic                                   req_force_req,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [fbcpe_pkg::COLUMN_WIDTH-1:0]     rsp_pixel_x,
   output logic [fbcpe_pkg::ROW_WIDTH-1:0]        rsp_pixel_y,
   output logic [fbcpe_pkg::RGB_WIDTH-1:0]        rsp_pixel_rgb,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fbcpe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fbcpe_pkg::RGB_WIDTH-1:0]        csr_data
);
   import fbcpe_pkg::*;

   logic [1:0]  pixel_mode_ff;
   palette_type palette_ff;
   logic        queue_ready, queue_push, head_valid, pop;
   item_type    queue_item, head_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff <= MODE_MONO;
         palette_ff[0] <= PALETTE_ZERO_RESET;
         palette_ff[1] <= PALETTE_ONE_RESET;
         palette_ff[2] <= PALETTE_TWO_RESET;
         palette_ff[3] <= PALETTE_THREE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_MODE:    pixel_mode_ff <= csr_data[1:0];
            CSR_PALETTE_ZERO:  palette_ff[0] <= csr_data;
            CSR_PALETTE_ONE:   palette_ff[1] <= csr_data;
            CSR_PALETTE_TWO:   palette_ff[2] <= csr_data;
            CSR_PALETTE_THREE: palette_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   fbcpe_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_row         (req_row),
      .req_word_column (req_word_column),
      .req_word_data   (req_word_data),
      .req_force_req   (req_force_req),
      .pixel_mode      (pixel_mode_ff),
      .queue_ready     (queue_ready),
      .queue_push      (queue_push),
      .queue_item      (queue_item)
   );

   fbcpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_item  (queue_item),
      .push_ready (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   fbcpe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .palette       (palette_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_pixel_rgb (rsp_pixel_rgb),
      .rsp_last      (rsp_last)
   );

endmodule
